[design/rhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// types, constants and helpers of the rgb / hsv colour converter
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam logic [1:0] FUNC_TO_HSV   = 2'd0;
    localparam logic [1:0] FUNC_TO_RGB   = 2'd1;
    localparam logic [1:0] FUNC_BRIGHTEN = 2'd2;

    localparam logic [14:0] HUE_FULL   = 15'd23040;
    localparam logic [11:0] HUE_SECTOR = 12'd3840;
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    // ceil(2^24 / 15), exact for dividends below 2^20
    localparam logic [20:0] RECIP15    = 21'd1118482;

    localparam int NUM_STAGES = 11;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] h;
        logic [16:0] s;
        logic [16:0] v;
        logic [15:0] gain;
        logic [7:0]  mx;
        logic [7:0]  delta;
        logic [14:0] base;
        logic        neg;
        logic        achro;
        logic [7:0]  sn_rem;
        logic [23:0] sn_num;
        logic [16:0] sn_q;
        logic [7:0]  hn_rem;
        logic [19:0] hn_num;
        logic [11:0] hn_q;
        logic [14:0] hue;
        logic [16:0] sat;
        logic [16:0] val;
        logic [32:0] prod;
        logic [2:0]  sec;
        logic [11:0] f;
        logic [33:0] pp;
        logic [28:0] sf;
        logic [28:0] sg;
        logic [16:0] p;
        logic [40:0] qdp;
        logic [40:0] tdp;
        logic [33:0] qm;
        logic [33:0] tm;
        logic [31:0] o_rgba;
        logic [14:0] o_hue;
        logic [16:0] o_sat;
        logic [16:0] o_val;
        logic        o_achro;
    } pipe_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                            input logic [7:0] dvs);
        logic [8:0] t;
        logic [8:0] d;
        t = {rem, nbit};
        d = {1'b0, dvs};
        if (t >= d)
        begin
            div_step = {1'b1, 8'(t - d)};
        end
        else
        begin
            div_step = {1'b0, t[7:0]};
        end
    endfunction

    // channel byte from a q1.16 level, times 255 and truncated
    function automatic logic [7:0] chan(input logic [16:0] x);
        logic [24:0] y;
        y = {x, 8'b0} - {8'b0, x};
        chan = y[23:16];
    endfunction

endpackage

[design/rgb_hsv_color_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter
// pipelined rgb to hsv, hsv to rgb and brighten converter, one pixel a clock unless the output stalls
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// input   | in_valid / in_stall  | func, rgba_in, hue_in, sat_in, val_in, gain
// output  | out_valid / out_stall| rgba_out, hue_out, sat_out, val_out, achromatic
//
// eleven register stages, one transfer per clock sustained while the output is not stalled
// four of them hold the two radix-2 dividers (saturation and hue fraction)
// reset clears only the stage valid bits
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] rgba_in,
    input  logic [14:0] hue_in,
    input  logic [16:0] sat_in,
    input  logic [16:0] val_in,
    input  logic [15:0] gain,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] rgba_out,
    output logic [14:0] hue_out,
    output logic [16:0] sat_out,
    output logic [16:0] val_out,
    output logic        achromatic
);
    import rhc_pkg::*;

    pipe_t                 st_reg  [1:NUM_STAGES];
    pipe_t                 st_next [1:NUM_STAGES];
    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   vld_next;
    logic                  en;

    assign en       = !vld_reg[NUM_STAGES] || !out_stall;
    assign in_stall = !en;
    assign vld_next = {vld_reg[NUM_STAGES-1:1], in_valid};

    always_comb
    begin
        pipe_t       cur;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  d;
        logic [8:0]  stp;
        logic [14:0] hs;
        logic [16:0] ss;
        logic [16:0] vs;
        logic [20:0] nv;
        logic [16:0] qd;
        logic [16:0] td;
        logic [16:0] q;
        logic [16:0] t;
        logic [16:0] rr;
        logic [16:0] gg;
        logic [16:0] bb;

        // stage 1: channel max / min and divider set-up, input clamps
        cur = '0;
        r   = rgba_in[31:24];
        g   = rgba_in[23:16];
        b   = rgba_in[15:8];
        mx  = r;
        mn  = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        cur.func  = func;
        cur.h     = (hue_in > HUE_FULL) ? HUE_FULL : hue_in;
        cur.s     = (sat_in > ONE_Q16) ? ONE_Q16 : sat_in;
        cur.v     = (val_in > ONE_Q16) ? ONE_Q16 : val_in;
        cur.gain  = gain;
        cur.mx    = mx;
        cur.delta = mx - mn;
        cur.achro = (mx == mn);
        if (r == mx)
        begin
            cur.base = 15'd0;
            hi = g;
            lo = b;
        end
        else if (g == mx)
        begin
            cur.base = {2'b0, HUE_SECTOR, 1'b0};
            hi = b;
            lo = r;
        end
        else
        begin
            cur.base = {1'b0, HUE_SECTOR, 2'b0};
            hi = r;
            lo = g;
        end
        cur.neg    = (hi < lo);
        d          = cur.neg ? (lo - hi) : (hi - lo);
        cur.hn_num = {({d, 4'b0} - {4'b0, d}), 8'b0};
        cur.sn_num = {cur.delta, 16'b0};
        st_next[1] = cur;

        // stages 2 to 5: six saturation and five hue division steps each
        for (int k = 2; k <= 5; k++)
        begin
            cur = st_reg[k-1];
            for (int i = 0; i < 6; i++)
            begin
                stp        = div_step(cur.sn_rem, cur.sn_num[23], cur.mx);
                cur.sn_rem = stp[7:0];
                cur.sn_q   = {cur.sn_q[15:0], stp[8]};
                cur.sn_num = {cur.sn_num[22:0], 1'b0};
            end
            for (int i = 0; i < 5; i++)
            begin
                stp        = div_step(cur.hn_rem, cur.hn_num[19], cur.delta);
                cur.hn_rem = stp[7:0];
                cur.hn_q   = {cur.hn_q[10:0], stp[8]};
                cur.hn_num = {cur.hn_num[18:0], 1'b0};
            end
            st_next[k] = cur;
        end

        // stage 6: hue, saturation, value and gain product
        cur = st_reg[5];
        if (cur.achro)
        begin
            cur.hue = 15'd0;
        end
        else if (cur.neg)
        begin
            cur.hue = (cur.base == 15'd0) ? (HUE_FULL - {3'b0, cur.hn_q})
                                          : (cur.base - {3'b0, cur.hn_q});
        end
        else
        begin
            cur.hue = cur.base + {3'b0, cur.hn_q};
        end
        cur.sat    = cur.achro ? 17'd0 : cur.sn_q;
        cur.val    = {1'b0, cur.mx, cur.mx} + {16'b0, (cur.mx == 8'hFF)};
        cur.prod   = {16'b0, cur.val} * {17'b0, cur.gain};
        st_next[6] = cur;

        // stage 7: operand select, sector and fraction
        cur = st_reg[6];
        nv  = cur.prod[32:12];
        if (cur.func == FUNC_BRIGHTEN)
        begin
            hs = cur.hue;
            ss = cur.sat;
            vs = (nv > {4'b0, ONE_Q16}) ? ONE_Q16 : nv[16:0];
        end
        else
        begin
            hs = cur.h;
            ss = cur.s;
            vs = cur.v;
        end
        if (hs == HUE_FULL) hs = 15'd0;
        cur.sec = 3'd0;
        for (int j = 1; j <= 5; j++)
        begin
            if (hs >= 15'(15'(j) * {3'b0, HUE_SECTOR})) cur.sec = 3'(j);
        end
        cur.f      = 12'(hs - 15'({12'b0, cur.sec} * {3'b0, HUE_SECTOR}));
        cur.s      = ss;
        cur.v      = vs;
        st_next[7] = cur;

        // stage 8: first products
        cur        = st_reg[7];
        cur.pp     = {17'b0, cur.v} * {17'b0, (ONE_Q16 - cur.s)};
        cur.sf     = {12'b0, cur.s} * {17'b0, cur.f};
        cur.sg     = {12'b0, cur.s} * {17'b0, (HUE_SECTOR - cur.f)};
        st_next[8] = cur;

        // stage 9: p, and division by 3840 through the reciprocal of 15
        cur        = st_reg[8];
        cur.p      = cur.pp[32:16];
        cur.qdp    = {21'b0, cur.sf[27:8]} * {20'b0, RECIP15};
        cur.tdp    = {21'b0, cur.sg[27:8]} * {20'b0, RECIP15};
        st_next[9] = cur;

        // stage 10: q and t products
        cur         = st_reg[9];
        qd          = cur.qdp[40:24];
        td          = cur.tdp[40:24];
        cur.qm      = {17'b0, cur.v} * {17'b0, (ONE_Q16 - qd)};
        cur.tm      = {17'b0, cur.v} * {17'b0, (ONE_Q16 - td)};
        st_next[10] = cur;

        // stage 11: sector select, channel bytes, result fields
        cur = st_reg[10];
        q   = cur.qm[32:16];
        t   = cur.tm[32:16];
        case (cur.sec)
            3'd0:
            begin
                rr = cur.v; gg = t;     bb = cur.p;
            end
            3'd1:
            begin
                rr = q;     gg = cur.v; bb = cur.p;
            end
            3'd2:
            begin
                rr = cur.p; gg = cur.v; bb = t;
            end
            3'd3:
            begin
                rr = cur.p; gg = q;     bb = cur.v;
            end
            3'd4:
            begin
                rr = t;     gg = cur.p; bb = cur.v;
            end
            default:
            begin
                rr = cur.v; gg = cur.p; bb = q;
            end
        endcase
        if (cur.s == 17'd0)
        begin
            rr = cur.v;
            gg = cur.v;
            bb = cur.v;
        end
        cur.o_rgba  = 32'd0;
        cur.o_hue   = 15'd0;
        cur.o_sat   = 17'd0;
        cur.o_val   = 17'd0;
        cur.o_achro = 1'b0;
        case (cur.func)
            FUNC_TO_HSV:
            begin
                cur.o_hue   = cur.hue;
                cur.o_sat   = cur.sat;
                cur.o_val   = cur.val;
                cur.o_achro = cur.achro;
            end
            FUNC_TO_RGB, FUNC_BRIGHTEN:
            begin
                cur.o_rgba = {chan(rr), chan(gg), chan(bb), 8'hFF};
            end
            default:
            begin
                cur.o_rgba = 32'd0;
            end
        endcase
        st_next[11] = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid  = vld_reg[NUM_STAGES];
    assign rgba_out   = st_reg[NUM_STAGES].o_rgba;
    assign hue_out    = st_reg[NUM_STAGES].o_hue;
    assign sat_out    = st_reg[NUM_STAGES].o_sat;
    assign val_out    = st_reg[NUM_STAGES].o_val;
    assign achromatic = st_reg[NUM_STAGES].o_achro;

endmodule
